// ----- design/per_session_bounded_queue_top_defines.svh -----
// ----------------------------------------------------------------------------
// per_session_bounded_queue_top_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef PER_SESSION_BOUNDED_QUEUE_TOP_DEFINES_SVH
`define PER_SESSION_BOUNDED_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define PSBQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/psbq_pkg.sv -----
// ----------------------------------------------------------------------------
// psbq_pkg
// types, codes and sizes of the per-session bounded queue
// ----------------------------------------------------------------------------
package psbq_pkg;

    localparam int NumSessions  = 16;
    localparam int SessionDepth = 16;
    localparam int SessBits     = $clog2(NumSessions);
    localparam int SlotBits     = $clog2(SessionDepth);
    localparam int AddrBits     = SessBits + SlotBits;
    localparam int MemDepth     = NumSessions * SessionDepth;

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_DRAIN = 3'd3;
    localparam logic [2:0] OP_SWEEP = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_MERGED   = 3'd1;
    localparam logic [2:0] ST_DROP_OLD = 3'd2;
    localparam logic [2:0] ST_DROP_NEW = 3'd3;
    localparam logic [2:0] ST_NOT_ACC  = 3'd4;
    localparam logic [2:0] ST_OK       = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    localparam logic [1:0] MODE_DROP_NEW = 2'd1;
    localparam logic [1:0] MODE_DROP_OLD = 2'd2;

    localparam logic [2:0] REG_SESSION_LIMIT = 3'd0;
    localparam logic [2:0] REG_GLOBAL_LIMIT  = 3'd1;
    localparam logic [2:0] REG_OVERFLOW_MODE = 3'd2;
    localparam logic [2:0] REG_COALESCE      = 3'd3;
    localparam logic [2:0] REG_AGE_LIMIT     = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  session;
        logic [31:0] payload;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_out;
        logic [4:0]  session_depth;
        logic [8:0]  total_count;
        logic [8:0]  dropped_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [4:0]  per_session_limit;
        logic [8:0]  global_limit;
        logic [1:0]  overflow_mode;
        logic        coalesce_enable;
        logic [31:0] age_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_PUSH,
        A_EMPTY,
        A_HEAD_RD,
        A_HEAD_OUT,
        A_DRAIN_START,
        A_DRAIN_STEP,
        A_SWEEP_OFF,
        A_SWEEP_INIT,
        A_SW_READ,
        A_SW_DROP,
        A_SW_NEXT,
        A_SWEEP_DONE,
        A_CLEAR
    } action_t;

    typedef struct packed {
        logic    load;
        action_t action;
    } dp_ctl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       age_off;
        logic       sw_end;
        logic       sw_expired;
        logic       drain_end;
    } dp_stat_t;

endpackage

// ----- design/psbq_cfg.sv -----
// ----------------------------------------------------------------------------
// psbq_cfg
// apb register bank for limits, overflow policy, coalescing and age limit
// ----------------------------------------------------------------------------
module psbq_cfg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output psbq_pkg::cfg_t       cfg
);
    import psbq_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.per_session_limit <= 5'd16;
            cfg_reg.global_limit      <= 9'd256;
            cfg_reg.overflow_mode     <= 2'd0;
            cfg_reg.coalesce_enable   <= 1'b0;
            cfg_reg.age_limit         <= 32'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SESSION_LIMIT: cfg_reg.per_session_limit <= pwdata[4:0];
                REG_GLOBAL_LIMIT:  cfg_reg.global_limit      <= pwdata[8:0];
                REG_OVERFLOW_MODE: cfg_reg.overflow_mode     <= pwdata[1:0];
                REG_COALESCE:      cfg_reg.coalesce_enable   <= pwdata[0];
                REG_AGE_LIMIT:     cfg_reg.age_limit         <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SESSION_LIMIT: prdata = {27'd0, cfg_reg.per_session_limit};
            REG_GLOBAL_LIMIT:  prdata = {23'd0, cfg_reg.global_limit};
            REG_OVERFLOW_MODE: prdata = {30'd0, cfg_reg.overflow_mode};
            REG_COALESCE:      prdata = {31'd0, cfg_reg.coalesce_enable};
            REG_AGE_LIMIT:     prdata = cfg_reg.age_limit;
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ----- design/psbq_ctrl.sv -----
// ----------------------------------------------------------------------------
// psbq_ctrl
// sequencer for push, pop, peek, drain, sweep and clear
// ----------------------------------------------------------------------------
module psbq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psbq_pkg::dp_stat_t   stat,
    output psbq_pkg::dp_ctl_t    ctl
);
    import psbq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_DRAIN,
        S_SW_RD,
        S_SW_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    assign busy      = busy_reg;
    assign busy_next = (state_next != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl.load   = 1'b0;
        ctl.action = A_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    OP_PUSH:
                        ctl.action = A_PUSH;
                    OP_POP, OP_PEEK:
                    begin
                        if (stat.empty)
                            ctl.action = A_EMPTY;
                        else
                        begin
                            ctl.action = A_HEAD_RD;
                            state_next = S_POP_RD;
                        end
                    end
                    OP_DRAIN:
                    begin
                        if (stat.empty)
                            ctl.action = A_EMPTY;
                        else
                        begin
                            ctl.action = A_DRAIN_START;
                            state_next = S_DRAIN;
                        end
                    end
                    OP_SWEEP:
                    begin
                        if (stat.age_off)
                            ctl.action = A_SWEEP_OFF;
                        else
                        begin
                            ctl.action = A_SWEEP_INIT;
                            state_next = S_SW_RD;
                        end
                    end
                    OP_CLEAR:
                        ctl.action = A_CLEAR;
                    default:
                        ctl.action = A_NONE;
                endcase
            end
            S_POP_RD:
            begin
                ctl.action = A_HEAD_OUT;
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                ctl.action = A_DRAIN_STEP;
                if (stat.drain_end)
                    state_next = S_IDLE;
            end
            S_SW_RD:
            begin
                if (stat.sw_end)
                begin
                    ctl.action = A_SWEEP_DONE;
                    state_next = S_IDLE;
                end
                else if (stat.empty)
                    ctl.action = A_SW_NEXT;
                else
                begin
                    ctl.action = A_SW_READ;
                    state_next = S_SW_CHK;
                end
            end
            S_SW_CHK:
            begin
                ctl.action = stat.sw_expired ? A_SW_DROP : A_SW_NEXT;
                state_next = S_SW_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ----- design/psbq_dp.sv -----
// ----------------------------------------------------------------------------
// psbq_dp
// queue storage, per-session pointers and result register
// ----------------------------------------------------------------------------
module psbq_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  psbq_pkg::cmd_t       cmd,
    input  psbq_pkg::cfg_t       cfg,
    input  psbq_pkg::dp_ctl_t    ctl,
    output psbq_pkg::dp_stat_t   stat,
    output logic                 result_valid,
    output psbq_pkg::result_t    result
);
    import psbq_pkg::*;

    logic [2:0]          op_reg;
    logic [SessBits-1:0] sess_reg;
    logic [31:0]         payload_reg;
    logic [31:0]         now_reg;

    logic [SlotBits:0]   fill_reg [NumSessions];
    logic [SlotBits-1:0] head_reg [NumSessions];
    logic [8:0]          total_reg;
    logic [8:0]          total_next;

    logic [31:0]         pay_mem   [MemDepth];
    logic [31:0]         stamp_mem [MemDepth];
    logic [31:0]         pay_rdata_reg;
    logic [31:0]         stamp_rdata_reg;

    logic [SlotBits-1:0] ptr_reg;
    logic [SlotBits-1:0] ptr_next;
    logic [SlotBits:0]   remain_reg;
    logic [SlotBits:0]   remain_next;
    logic [SessBits:0]   sw_idx_reg;
    logic [SessBits:0]   sw_idx_next;
    logic [8:0]          dropped_reg;
    logic [8:0]          dropped_next;

    logic                res_valid_reg;
    logic                res_valid_next;
    result_t             res_reg;
    result_t             res_next;

    logic [SessBits-1:0] idx;
    logic [SlotBits:0]   fill_cur;
    logic [SlotBits-1:0] head_cur;
    logic                upd_en;
    logic [SlotBits:0]   upd_fill;
    logic [SlotBits-1:0] upd_head;
    logic                clear_all;
    logic                wr_en;
    logic [SlotBits-1:0] wr_off;
    logic                rd_en;
    logic [AddrBits-1:0] rd_addr;
    logic                over;
    logic [31:0]         age;

    assign idx      = (op_reg == OP_SWEEP) ? sw_idx_reg[SessBits-1:0] : sess_reg;
    assign fill_cur = fill_reg[idx];
    assign head_cur = head_reg[idx];
    assign over     = (fill_cur >= cfg.per_session_limit) || (total_reg >= cfg.global_limit);
    assign age      = now_reg - stamp_rdata_reg;

    assign stat.op         = op_reg;
    assign stat.empty      = (fill_cur == '0);
    assign stat.age_off    = (cfg.age_limit == 32'd0);
    assign stat.sw_end     = sw_idx_reg[SessBits];
    assign stat.sw_expired = (age > cfg.age_limit);
    assign stat.drain_end  = (remain_reg == {{SlotBits{1'b0}}, 1'b1});

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        upd_en         = 1'b0;
        upd_fill       = fill_cur;
        upd_head       = head_cur;
        total_next     = total_reg;
        clear_all      = 1'b0;
        wr_en          = 1'b0;
        wr_off         = head_cur + fill_cur[SlotBits-1:0];
        rd_en          = 1'b0;
        rd_addr        = {idx, head_cur};
        ptr_next       = ptr_reg;
        remain_next    = remain_reg;
        sw_idx_next    = sw_idx_reg;
        dropped_next   = dropped_reg;
        res_valid_next = 1'b0;
        res_next       = '0;
        res_next.last  = 1'b1;
        case (ctl.action)
            A_PUSH:
            begin
                res_valid_next = 1'b1;
                if (cfg.coalesce_enable && (fill_cur != '0))
                begin
                    wr_en           = 1'b1;
                    wr_off          = head_cur + fill_cur[SlotBits-1:0] - 1'b1;
                    res_next.status = ST_MERGED;
                end
                else if (over)
                begin
                    if (cfg.overflow_mode == MODE_DROP_OLD)
                    begin
                        wr_en           = 1'b1;
                        upd_en          = 1'b1;
                        res_next.status = ST_DROP_OLD;
                        if (fill_cur != '0)
                            upd_head = head_cur + 1'b1;
                        else
                        begin
                            upd_fill   = fill_cur + 1'b1;
                            total_next = total_reg + 9'd1;
                        end
                    end
                    else if (cfg.overflow_mode == MODE_DROP_NEW)
                        res_next.status = ST_DROP_NEW;
                    else
                        res_next.status = ST_NOT_ACC;
                end
                else if (fill_cur[SlotBits])
                    res_next.status = ST_NOT_ACC;
                else
                begin
                    wr_en           = 1'b1;
                    upd_en          = 1'b1;
                    upd_fill        = fill_cur + 1'b1;
                    total_next      = total_reg + 9'd1;
                    res_next.status = ST_ACCEPTED;
                end
                res_next.session_depth = 5'(upd_fill);
                res_next.total_count   = total_next;
            end
            A_EMPTY:
            begin
                res_valid_next       = 1'b1;
                res_next.status      = ST_EMPTY;
                res_next.total_count = total_reg;
            end
            A_HEAD_RD:
                rd_en = 1'b1;
            A_HEAD_OUT:
            begin
                if (op_reg == OP_POP)
                begin
                    upd_en     = 1'b1;
                    upd_fill   = fill_cur - 1'b1;
                    upd_head   = head_cur + 1'b1;
                    total_next = total_reg - 9'd1;
                end
                res_valid_next         = 1'b1;
                res_next.status        = ST_OK;
                res_next.data_out      = pay_rdata_reg;
                res_next.session_depth = 5'(upd_fill);
                res_next.total_count   = total_next;
            end
            A_DRAIN_START:
            begin
                rd_en       = 1'b1;
                ptr_next    = head_cur + 1'b1;
                remain_next = fill_cur;
                upd_en      = 1'b1;
                upd_fill    = '0;
                upd_head    = '0;
                total_next  = total_reg - 9'(fill_cur);
            end
            A_DRAIN_STEP:
            begin
                rd_en                = 1'b1;
                rd_addr              = {sess_reg, ptr_reg};
                ptr_next             = ptr_reg + 1'b1;
                remain_next          = remain_reg - 1'b1;
                res_valid_next       = 1'b1;
                res_next.status      = ST_OK;
                res_next.data_out    = pay_rdata_reg;
                res_next.total_count = total_reg;
                res_next.last        = stat.drain_end;
            end
            A_SWEEP_OFF:
            begin
                res_valid_next       = 1'b1;
                res_next.status      = ST_DONE;
                res_next.total_count = total_reg;
            end
            A_SWEEP_INIT:
            begin
                sw_idx_next  = '0;
                dropped_next = '0;
            end
            A_SW_READ:
                rd_en = 1'b1;
            A_SW_DROP:
            begin
                upd_en       = 1'b1;
                upd_fill     = fill_cur - 1'b1;
                upd_head     = head_cur + 1'b1;
                total_next   = total_reg - 9'd1;
                dropped_next = dropped_reg + 9'd1;
            end
            A_SW_NEXT:
            begin
                upd_en      = 1'b1;
                if (fill_cur == '0)
                    upd_head = '0;
                sw_idx_next = sw_idx_reg + 1'b1;
            end
            A_SWEEP_DONE:
            begin
                res_valid_next         = 1'b1;
                res_next.status        = ST_DONE;
                res_next.total_count   = total_reg;
                res_next.dropped_count = dropped_reg;
            end
            A_CLEAR:
            begin
                clear_all       = 1'b1;
                total_next      = '0;
                res_valid_next  = 1'b1;
                res_next.status = ST_DONE;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg      <= cmd.opcode;
            sess_reg    <= cmd.session[SessBits-1:0];
            payload_reg <= cmd.payload;
            now_reg     <= cmd.now;
        end
        ptr_reg     <= ptr_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumSessions; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            total_reg     <= '0;
            remain_reg    <= '0;
            sw_idx_reg    <= '0;
            dropped_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                for (int i = 0; i < NumSessions; i++)
                begin
                    fill_reg[i] <= '0;
                    head_reg[i] <= '0;
                end
            end
            else if (upd_en)
            begin
                fill_reg[idx] <= upd_fill;
                head_reg[idx] <= upd_head;
            end
            total_reg     <= total_next;
            remain_reg    <= remain_next;
            sw_idx_reg    <= sw_idx_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pay_mem[{idx, wr_off}]   <= payload_reg;
            stamp_mem[{idx, wr_off}] <= now_reg;
        end
        if (rd_en)
        begin
            pay_rdata_reg   <= pay_mem[rd_addr];
            stamp_rdata_reg <= stamp_mem[rd_addr];
        end
    end

endmodule

// ----- design/per_session_bounded_queue_top.sv -----
// ----------------------------------------------------------------------------
// per_session_bounded_queue_top
// per-session fifos with bounds, overflow policy, drain and age sweep
//
//   port group     dir   handshake
//   cmd            in    start high, busy low
//   result         out   result_valid, one cycle, no backpressure
//   apb config     in    psel, penable, pwrite, pready
//
// push, clear and ignored opcodes finish in the exec state; pop and peek add one
// registered memory read; drain issues one result a cycle until the session is empty
// sweep walks the sessions, skips empty ones and reads and checks each head entry,
// dropping expired heads, bounded by the single memory read port
// reset clears pointers and counts at once; entries are undefined until written
// results cannot be stalled; busy stays high until the last result issues
// ----------------------------------------------------------------------------
module per_session_bounded_queue_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psbq_pkg::cmd_t       cmd,
    output logic                 result_valid,
    output psbq_pkg::result_t    result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import psbq_pkg::*;

    cfg_t     cfg;
    dp_ctl_t  ctl;
    dp_stat_t stat;

    psbq_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psbq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    psbq_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .ctl          (ctl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- design/psbq_checker.sv -----
// ----------------------------------------------------------------------------
// psbq_checker
// port-level checks on item acceptance, result sequencing and result contents
// ----------------------------------------------------------------------------
`include "per_session_bounded_queue_top_defines.svh"

module psbq_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 result_valid,
    input psbq_pkg::result_t    result
);
    import psbq_pkg::*;

    `PSBQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `PSBQ_ASSERT_NEXT(a_last_gap, result_valid && result.last, !result_valid, "result right after last")
    `PSBQ_ASSERT_NEXT(a_drain_burst, result_valid && !result.last, result_valid, "drain burst broken")
    `PSBQ_ASSERT_NOW(a_empty_zero, result_valid && (result.status == ST_EMPTY), (result.session_depth == 5'd0) && (result.data_out == 32'd0), "empty result carries data")
    `PSBQ_ASSERT_NOW(a_total_bound, result_valid, result.total_count <= 9'd256, "total count out of range")

endmodule

bind per_session_bounded_queue_top psbq_checker u_psbq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
